// File: hw/rtl/mi3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants for the 3x3 matrix inverse unit.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int FIELD_W        = 32;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int NUM_ELEM       = 9;
	localparam int FRONT_LAT      = 6;

endpackage

// File: hw/rtl/mi3_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_front
// Cofactor and determinant pipeline; prepares magnitudes for the divide lanes.
// ----------------------------------------------------------------------------
module mi3_front #(
	parameter int EW = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic [mi3_pkg::NUM_ELEM-1:0][mi3_pkg::FIELD_W-1:0] elem,
	output logic [mi3_pkg::NUM_ELEM-1:0][2*EW+1+2*FRAC_BITS-1:0] num_abs,
	output logic [3*EW+1:0] den_abs,
	output logic [mi3_pkg::NUM_ELEM-1:0] neg,
	output logic singular,
	output logic [EW-1:0] det_sat
);

	localparam int CW   = 2*EW + 1;
	localparam int DETW = 3*EW + 2;
	localparam int NUMW = CW + 2*FRAC_BITS;
	localparam int NE   = mi3_pkg::NUM_ELEM;

	// Cofactor i = a[IA]*a[IB] - a[IC]*a[ID], elements in column-major order.
	localparam int IA [0:8] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
	localparam int IB [0:8] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
	localparam int IC [0:8] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};
	localparam int ID [0:8] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};

	logic signed [EW-1:0]   a      [0:NE-1];
	logic signed [2*EW-1:0] pa_s1  [0:NE-1];
	logic signed [2*EW-1:0] pb_s1  [0:NE-1];
	logic signed [EW-1:0]   n_s1   [0:2];
	logic signed [EW-1:0]   n_s2   [0:2];
	logic signed [CW-1:0]   cof_s2 [0:NE-1];
	logic signed [CW-1:0]   cof_s3 [0:NE-1];
	logic signed [CW-1:0]   cof_s4 [0:NE-1];
	logic signed [CW-1:0]   cof_s5 [0:NE-1];
	logic signed [CW-1:0]   plo_s3 [0:2];
	logic signed [CW-1:0]   phi_s3 [0:2];
	logic signed [DETW-1:0] term_s4 [0:2];
	logic signed [DETW-1:0] det_s5;
	logic signed [DETW-1:0] det_sh;
	logic [DETW-EW:0]       det_top;

	genvar gi;
	generate
		for (gi = 0; gi < NE; gi++) begin : g_elem
			assign a[gi] = $signed(elem[gi][EW-1:0]);

			always_ff @(posedge clk) begin
				pa_s1[gi]  <= a[IA[gi]] * a[IB[gi]];
				pb_s1[gi]  <= a[IC[gi]] * a[ID[gi]];
				cof_s2[gi] <= CW'(pa_s1[gi]) - CW'(pb_s1[gi]);
				cof_s3[gi] <= cof_s2[gi];
				cof_s4[gi] <= cof_s3[gi];
				cof_s5[gi] <= cof_s4[gi];
				num_abs[gi] <= {(cof_s5[gi][CW-1] ? CW'(-cof_s5[gi]) : CW'(cof_s5[gi])),
					{(2*FRAC_BITS){1'b0}}};
				neg[gi] <= cof_s5[gi][CW-1] ^ det_s5[DETW-1];
			end
		end

		// Determinant is expanded down the first column; the wide cofactor is
		// split into an unsigned low half and a signed high half.
		for (gi = 0; gi < 3; gi++) begin : g_det
			always_ff @(posedge clk) begin
				n_s1[gi]    <= a[gi];
				n_s2[gi]    <= n_s1[gi];
				plo_s3[gi]  <= n_s2[gi] * $signed({1'b0, cof_s2[3*gi][EW-1:0]});
				phi_s3[gi]  <= n_s2[gi] * $signed(cof_s2[3*gi][CW-1:EW]);
				term_s4[gi] <= (DETW'(phi_s3[gi]) <<< EW) + DETW'(plo_s3[gi]);
			end
		end
	endgenerate

	assign det_sh  = det_s5 >>> (2*FRAC_BITS);
	assign det_top = det_sh[DETW-1:EW-1];

	always_ff @(posedge clk) begin
		det_s5   <= term_s4[0] + term_s4[1] + term_s4[2];
		den_abs  <= det_s5[DETW-1] ? DETW'(-det_s5) : DETW'(det_s5);
		singular <= (det_s5 == '0);
		if ((&det_top) || !(|det_top)) begin
			det_sat <= det_sh[EW-1:0];
		end else begin
			det_sat <= det_s5[DETW-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
		end
	end

endmodule

// File: hw/rtl/mi3_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divider, one quotient bit per stage, saturating result.
// ----------------------------------------------------------------------------
module mi3_div_lane #(
	parameter int EW   = 32,
	parameter int NUMW = 97,
	parameter int DETW = 98
) (
	input  logic            clk,
	input  logic [NUMW-1:0] num,
	input  logic [DETW-1:0] den,
	input  logic            neg,
	output logic [EW-1:0]   quot
);

	localparam int WW = ((NUMW > DETW + EW) ? NUMW : DETW + EW) + 1;

	logic [WW-1:0] rem_s [0:EW];
	logic [WW-1:0] den_s [0:EW];
	logic [EW-1:0] q_s   [0:EW];
	logic          neg_s [0:EW];
	logic          ovf_s [0:EW];

	// The quotient no longer fits the EW-bit quotient register once it reaches 2^EW.
	always_ff @(posedge clk) begin
		rem_s[0] <= WW'(num);
		den_s[0] <= WW'(den);
		q_s[0]   <= '0;
		neg_s[0] <= neg;
		ovf_s[0] <= WW'(num) >= (WW'(den) << EW);
	end

	genvar gk;
	generate
		for (gk = 1; gk <= EW; gk++) begin : g_stage
			logic [WW:0] trial;
			assign trial = {1'b0, rem_s[gk-1]} - {1'b0, den_s[gk-1] << (EW - gk)};

			always_ff @(posedge clk) begin
				rem_s[gk] <= trial[WW] ? rem_s[gk-1] : trial[WW-1:0];
				q_s[gk]   <= {q_s[gk-1][EW-2:0], ~trial[WW]};
				den_s[gk] <= den_s[gk-1];
				neg_s[gk] <= neg_s[gk-1];
				ovf_s[gk] <= ovf_s[gk-1];
			end
		end
	endgenerate

	always_comb begin
		if (!neg_s[EW]) begin
			quot = (ovf_s[EW] || q_s[EW][EW-1]) ? {1'b0, {(EW-1){1'b1}}} : q_s[EW];
		end else if (ovf_s[EW] || (q_s[EW] > {1'b1, {(EW-1){1'b0}}})) begin
			quot = {1'b1, {(EW-1){1'b0}}};
		end else begin
			quot = EW'(-q_s[EW]);
		end
	end

endmodule

// File: hw/rtl/mi3_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_merge
// Gathers the lane quotients, applies transpose and the singular override.
// ----------------------------------------------------------------------------
module mi3_merge #(
	parameter int EW = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic valid,
	input  logic transpose,
	input  logic [mi3_pkg::NUM_ELEM-1:0][EW-1:0] quot,
	input  logic singular_in,
	input  logic [EW-1:0] det_in,
	output logic [mi3_pkg::NUM_ELEM-1:0][mi3_pkg::FIELD_W-1:0] res,
	output logic [mi3_pkg::FIELD_W-1:0] det_out,
	output logic singular_out,
	output logic done
);

	localparam int FW = mi3_pkg::FIELD_W;
	localparam int TP [0:8] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};
	localparam logic [EW-1:0] ONE = (FRAC_BITS < EW - 1) ?
		EW'(1) << FRAC_BITS : {1'b0, {(EW-1){1'b1}}};

	genvar gi;
	generate
		for (gi = 0; gi < mi3_pkg::NUM_ELEM; gi++) begin : g_out
			always_ff @(posedge clk) begin
				if (singular_in) begin
					res[gi] <= (gi % 4 == 0) ? FW'($signed(ONE)) : '0;
				end else if (transpose) begin
					res[gi] <= FW'($signed(quot[TP[gi]]));
				end else begin
					res[gi] <= FW'($signed(quot[gi]));
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		det_out      <= singular_in ? '0 : FW'($signed(det_in));
		singular_out <= singular_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid;
		end
	end

endmodule

// File: hw/rtl/matrix3_inverse_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_unit
// 3x3 matrix inverse by adjugate over nine parallel divide lanes.
// ----------------------------------------------------------------------------
// From start to done a matrix passes the six-stage cofactor/determinant front,
// the one-bit-per-stage dividers and the output register. Throughput: one
// matrix every cycle, busy is always low and every done beat must be taken.
// Reset clears the pipeline valid chain and the transpose bit.
module matrix3_inverse_unit #(
	parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic [31:0] in_r1c1,
	input  logic [31:0] in_r2c1,
	input  logic [31:0] in_r3c1,
	input  logic [31:0] in_r1c2,
	input  logic [31:0] in_r2c2,
	input  logic [31:0] in_r3c2,
	input  logic [31:0] in_r1c3,
	input  logic [31:0] in_r2c3,
	input  logic [31:0] in_r3c3,
	output logic        done,
	output logic [31:0] out_r1c1,
	output logic [31:0] out_r2c1,
	output logic [31:0] out_r3c1,
	output logic [31:0] out_r1c2,
	output logic [31:0] out_r2c2,
	output logic [31:0] out_r3c2,
	output logic [31:0] out_r1c3,
	output logic [31:0] out_r2c3,
	output logic [31:0] out_r3c3,
	output logic [31:0] det_value,
	output logic        singular
);

	localparam int FW   = mi3_pkg::FIELD_W;
	localparam int NE   = mi3_pkg::NUM_ELEM;
	localparam int EW   = (DATA_WIDTH < FW) ? DATA_WIDTH : FW;
	localparam int DETW = 3*EW + 2;
	localparam int NUMW = 2*EW + 1 + 2*FRAC_BITS;
	localparam int DLAT = EW + 1;
	localparam int VLAT = mi3_pkg::FRONT_LAT + DLAT;

	logic [NE-1:0][FW-1:0]   elem;
	logic [NE-1:0][NUMW-1:0] num_abs;
	logic [DETW-1:0]         den_abs;
	logic [NE-1:0]           neg;
	logic                    sing_f;
	logic [EW-1:0]           det_f;
	logic [NE-1:0][EW-1:0]   quot;
	logic [NE-1:0][FW-1:0]   res;
	logic [VLAT-1:0]         valid_q;
	logic                    sing_q [0:DLAT-1];
	logic [EW-1:0]           det_q  [0:DLAT-1];
	logic                    transpose_q;

	assign busy = 1'b0;
	assign elem = {in_r3c3, in_r2c3, in_r1c3, in_r3c2, in_r2c2, in_r1c2,
		in_r3c1, in_r2c1, in_r1c1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			transpose_q <= 1'b0;
		end else begin
			valid_q <= {valid_q[VLAT-2:0], start};
			if (cfg_wr_en) begin
				transpose_q <= cfg_wr_data;
			end
		end
	end

	// Determinant side data waits alongside the divide lanes.
	always_ff @(posedge clk) begin
		sing_q[0] <= sing_f;
		det_q[0]  <= det_f;
		for (int i = 1; i < DLAT; i++) begin
			sing_q[i] <= sing_q[i-1];
			det_q[i]  <= det_q[i-1];
		end
	end

	mi3_front #(.EW(EW), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.elem     (elem),
		.num_abs  (num_abs),
		.den_abs  (den_abs),
		.neg      (neg),
		.singular (sing_f),
		.det_sat  (det_f)
	);

	genvar gi;
	generate
		for (gi = 0; gi < NE; gi++) begin : g_lane
			mi3_div_lane #(.EW(EW), .NUMW(NUMW), .DETW(DETW)) u_lane (
				.clk  (clk),
				.num  (num_abs[gi]),
				.den  (den_abs),
				.neg  (neg[gi]),
				.quot (quot[gi])
			);
		end
	endgenerate

	mi3_merge #(.EW(EW), .FRAC_BITS(FRAC_BITS)) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (valid_q[VLAT-1]),
		.transpose    (transpose_q),
		.quot         (quot),
		.singular_in  (sing_q[DLAT-1]),
		.det_in       (det_q[DLAT-1]),
		.res          (res),
		.det_out      (det_value),
		.singular_out (singular),
		.done         (done)
	);

	assign out_r1c1 = res[0];
	assign out_r2c1 = res[1];
	assign out_r3c1 = res[2];
	assign out_r1c2 = res[3];
	assign out_r2c2 = res[4];
	assign out_r3c2 = res[5];
	assign out_r1c3 = res[6];
	assign out_r2c3 = res[7];
	assign out_r3c3 = res[8];

endmodule
